// ===== src/cjet_pkg.sv =====
// shared types, constants and helpers for the cubic julia escape-time unit
// no dependencies
package cjet_pkg;

	localparam int QW = 32;
	localparam int FRAC = 24;
	localparam int CODE_W = 19;
	localparam int LIMIT_W = 16;
	localparam int ADDR_W = 4;
	localparam int EXT_W = 48;

	localparam logic [63:0] ESCAPE_BOUND = 64'd1000 << 48;
	localparam logic signed [EXT_W-1:0] Q_ONE = EXT_W'(1) <<< FRAC;

	localparam logic signed [QW-1:0] COEFF_A_RST = 32'sd31037850;
	localparam logic signed [QW-1:0] COEFF_B_RST = 32'sd0;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd100;

	typedef enum logic [1:0] {
		REG_COEFF_A = 2'd0,
		REG_COEFF_B = 2'd1,
		REG_LIMIT   = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_RR   = 12'b0000_0000_0010,
		S_II   = 12'b0000_0000_0100,
		S_CHK  = 12'b0000_0000_1000,
		S_SRE  = 12'b0000_0001_0000,
		S_DIM  = 12'b0000_0010_0000,
		S_PRE  = 12'b0000_0100_0000,
		S_TIM  = 12'b0000_1000_0000,
		S_PIM  = 12'b0001_0000_0000,
		S_TRE  = 12'b0010_0000_0000,
		S_FIN  = 12'b0100_0000_0000,
		S_OUT  = 12'b1000_0000_0000
	} state_t;

	// value fits the signed q8.24 range
	function automatic logic fits_q(input logic signed [EXT_W-1:0] v);
		logic [EXT_W-QW:0] top;
		top = v[EXT_W-1:QW-1];
		return (top == '0) || (top == '1);
	endfunction

	// floor a full q16.48 product down to q24.24 (arithmetic shift floors)
	function automatic logic signed [EXT_W-1:0] floor_q(input logic signed [63:0] prod);
		logic signed [63:0] sh;
		sh = prod >>> FRAC;
		return sh[EXT_W-1:0];
	endfunction

	// 3*n + low, n at most 65535
	function automatic logic signed [CODE_W-1:0] esc_code(input logic [LIMIT_W:0] n,
			input logic low);
		logic [CODE_W-1:0] c;
		c = {1'b0, n, 1'b0} + {2'b00, n} + {{(CODE_W-1){1'b0}}, low};
		return signed'(c);
	endfunction

endpackage

// ===== src/cubic_julia_escape_time_unit.sv =====
// cubic julia escape-time unit: iterates z <- z*P + b on one shared multiplier
// depends on cjet_pkg
//
// each iteration steps through the states S_RR to S_FIN in order; a bounded point or an escape
//   by the magnitude test goes to S_OUT before the result beat, an overflow ends its iteration early;
//   the 32x32 multiplier is shared by eight products of each iteration
// throughput: one point at a time, busy stays high from accept until the result beat
// the result beat is a one-cycle strobe; the receiver cannot stall it
// reset (arst_n low, asynchronous) returns to idle and restores the register defaults
module cubic_julia_escape_time_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [cjet_pkg::QW-1:0]       start_re,
	input  logic signed [cjet_pkg::QW-1:0]       start_im,
	output logic                                 done,
	output logic signed [cjet_pkg::CODE_W-1:0]   result_code,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cjet_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import cjet_pkg::*;

	// configuration registers
	logic signed [QW-1:0]   coeff_a_q, coeff_b_q;
	logic [LIMIT_W-1:0]     limit_q;
	reg_idx_t               widx;
	logic                   wr_en;

	// sequencer and datapath registers
	state_t                 state_q;
	logic signed [QW-1:0]   re_q, im_q;         // current z
	logic [LIMIT_W-1:0]     n_q;                // iterations done
	logic signed [63:0]     prod_q;             // shared multiplier output register
	logic [63:0]            mag_q;              // re^2 held for the escape test
	logic signed [QW-1:0]   s_q, d_q, p_q, tmp2_q;
	logic signed [EXT_W-1:0] imim_q, pre_q, pim_q, nre_q;
	logic signed [CODE_W-1:0] code_q;
	logic                   done_q;

	// shared multiplier operands
	logic signed [QW-1:0]   mul_a, mul_b;

	// combinational step values
	logic [64:0]            mag;
	logic signed [EXT_W-1:0] re_x, a_x, b_x, s_x, d_x, tmp1_x, p_x;
	logic signed [EXT_W-1:0] tmp2_x, tmp3_x, nre_x, nim_x, pf;
	logic [LIMIT_W:0]       n_inc;
	logic                   nre_pos, re_pos;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_COEFF_A: prdata = coeff_a_q;
			REG_COEFF_B: prdata = coeff_b_q;
			REG_LIMIT:   prdata = {16'd0, limit_q};
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= COEFF_A_RST;
			coeff_b_q <= COEFF_B_RST;
			limit_q   <= LIMIT_RST;
		end else if (wr_en) begin
			unique case (widx)
				REG_COEFF_A: coeff_a_q <= signed'(pwdata);
				REG_COEFF_B: coeff_b_q <= signed'(pwdata);
				REG_LIMIT:   limit_q   <= pwdata[LIMIT_W-1:0];
				default:     ;
			endcase
		end
	end

	// operand select: each state launches one product, consumed in the next state
	always_comb begin
		unique case (state_q)
			S_RR:    begin mul_a = re_q;   mul_b = re_q; end
			S_II:    begin mul_a = im_q;   mul_b = im_q; end
			S_SRE:   begin mul_a = s_q;    mul_b = re_q; end
			S_DIM:   begin mul_a = d_q;    mul_b = im_q; end
			S_PRE:   begin mul_a = p_q;    mul_b = re_q; end
			S_TIM:   begin mul_a = tmp2_q; mul_b = im_q; end
			S_PIM:   begin mul_a = p_q;    mul_b = im_q; end
			S_TRE:   begin mul_a = tmp2_q; mul_b = re_q; end
			default: begin mul_a = re_q;   mul_b = im_q; end
		endcase
	end

	// step arithmetic, all in a 48-bit signed frame so range checks are exact
	always_comb begin
		re_x    = EXT_W'(re_q);
		a_x     = EXT_W'(coeff_a_q);
		b_x     = EXT_W'(coeff_b_q);
		pf      = floor_q(prod_q);
		mag     = {1'b0, mag_q} + {1'b0, prod_q[63:0]};
		s_x     = a_x - re_x;
		d_x     = a_x - (re_x <<< 1);
		tmp1_x  = pf + imim_q;
		p_x     = tmp1_x + Q_ONE;
		tmp2_x  = pf;
		tmp3_x  = pre_q - pf;
		nre_x   = tmp3_x + b_x;
		nim_x   = pim_q + pf;
		n_inc   = {1'b0, n_q} + 1'b1;
		nre_pos = !nre_q[EXT_W-1] && (nre_q != '0);
		re_pos  = !re_q[QW-1] && (re_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_OUT);
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_RR;
				S_RR: begin
					// limit reached before the next escape test: bounded
					if (n_q >= limit_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_II;
					end
				end
				S_II:  state_q <= S_CHK;
				S_CHK: begin
					if (mag[64:0] >= {1'b0, ESCAPE_BOUND}) begin
						state_q <= S_OUT;
					end else if (!fits_q(s_x) || !fits_q(d_x)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SRE;
					end
				end
				S_SRE: state_q <= S_DIM;
				S_DIM: state_q <= (fits_q(tmp1_x) && fits_q(p_x)) ? S_PRE : S_OUT;
				S_PRE: state_q <= fits_q(tmp2_x) ? S_TIM : S_OUT;
				S_TIM: state_q <= S_PIM;
				S_PIM: state_q <= fits_q(tmp3_x) ? S_TRE : S_OUT;
				S_TRE: state_q <= S_FIN;
				S_FIN: state_q <= (fits_q(nre_q) && fits_q(nim_x)) ? S_RR : S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				re_q <= start_re;
				im_q <= start_im;
				n_q  <= '0;
			end
			S_RR: code_q <= '1;
			S_II: mag_q  <= prod_q;
			S_CHK: begin
				imim_q <= pf;
				s_q    <= s_x[QW-1:0];
				d_q    <= d_x[QW-1:0];
				if (mag[64:0] >= {1'b0, ESCAPE_BOUND}) begin
					code_q <= esc_code({1'b0, n_q}, !re_pos);
				end else begin
					n_q    <= n_inc[LIMIT_W-1:0];
					code_q <= esc_code(n_inc, 1'b1);
				end
			end
			S_DIM: p_q    <= p_x[QW-1:0];
			S_PRE: tmp2_q <= tmp2_x[QW-1:0];
			S_TIM: pre_q  <= pf;
			S_PIM: nre_q  <= nre_x;
			S_TRE: pim_q  <= pf;
			S_FIN: begin
				// escape on the new point: sign of the new real part picks the low code
				code_q <= esc_code({1'b0, n_q}, !nre_pos);
				re_q   <= nre_q[QW-1:0];
				im_q   <= nim_x[QW-1:0];
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign result_code = code_q;

	// accepted beat starts work
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not start the sequencer");

	// result beat only follows the output state and leaves the unit idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(state_q == S_OUT))
		else $error("result beat outside the output step");

	// strobe lasts exactly one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// a bounded point always reports minus one
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == S_RR) && state_q == S_OUT |=> result_code == '1)
		else $error("bounded point reported a count");

endmodule
